### sv/mdp_pkg.sv
// ----------------------------------------------------------------------------
// mdp_pkg
// Types, constants and codes shared by the matrix dot product engine.
// ----------------------------------------------------------------------------
`default_nettype none

package mdp_pkg;

    localparam int MAX_DIM = 16;
    localparam int IDX_W   = $clog2(MAX_DIM);
    localparam int ADDR_W  = 2 * IDX_W;
    localparam int DEPTH   = MAX_DIM * MAX_DIM;
    localparam int LEN_W   = $clog2(MAX_DIM + 1);

    localparam int FIELD_W = 4;
    localparam int DIM_W   = 5;
    localparam int DATA_W  = 32;

    localparam logic [DIM_W-1:0] DIM_RESET = DIM_W'(10);

    localparam logic [1:0] FUNC_WRITE_A = 2'd0;
    localparam logic [1:0] FUNC_WRITE_B = 2'd1;
    localparam logic [1:0] FUNC_COMPUTE = 2'd2;

    typedef struct packed {
        logic [1:0]                func;
        logic [FIELD_W-1:0]        row;
        logic [FIELD_W-1:0]        column;
        logic signed [DATA_W-1:0]  value;
    } in_item_t;

    typedef struct packed {
        logic signed [DATA_W-1:0]  product;
        logic [FIELD_W-1:0]        out_row;
        logic [FIELD_W-1:0]        out_column;
    } out_item_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ISSUE,
        ST_DRAIN,
        ST_FINISH
    } state_t;

    typedef struct packed {
        logic             wr_a;
        logic             wr_b;
        logic             start;
        logic             issue;
        logic [IDX_W-1:0] rd_index;
        logic             load_out;
    } cmd_t;

    typedef struct packed {
        logic busy;
    } status_t;

endpackage

`default_nettype wire

### sv/matrix_dot_product_engine.sv
// ----------------------------------------------------------------------------
// matrix_dot_product_engine
// Integer matrix multiply engine: stores A and B, returns one C element
// per compute request.
// ----------------------------------------------------------------------------
//  channel  dir  ports                      word
//  s_       in   s_valid s_ready s_data     func, row, column, value
//  m_       out  m_valid m_ready m_data     product, out_row, out_column
//  cfg_     in   cfg_wr_en cfg_wr_data      dimension, written at once
//
//  a write word is taken in idle; a compute word runs issue (skipped if
//  the sum is empty), drain and finish, and the next word waits for its
//  result to load; len = min(dimension, MAX_DIM); one multiply-accumulate
//  per issue cycle over one read port of each matrix memory
//  reset is synchronous, active low; matrix contents are not cleared
//  a waiting result does not block write words; a compute word finishes
//  only once the output register is free
// ----------------------------------------------------------------------------
`default_nettype none

module matrix_dot_product_engine (
    input  wire logic                      aclk,
    input  wire logic                      aresetn,
    input  wire logic                      cfg_wr_en,
    input  wire logic [mdp_pkg::DIM_W-1:0] cfg_wr_data,
    input  wire logic                      s_valid,
    output logic                           s_ready,
    input  wire mdp_pkg::in_item_t         s_data,
    output logic                           m_valid,
    input  wire logic                      m_ready,
    output mdp_pkg::out_item_t             m_data
);

    mdp_pkg::cmd_t    cmd;
    mdp_pkg::status_t status;

    mdp_controller u_ctrl (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .in_item     (s_data),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .cmd         (cmd),
        .status      (status)
    );

    mdp_datapath u_dp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_item  (s_data),
        .cmd      (cmd),
        .status   (status),
        .out_item (m_data)
    );

`ifndef SYNTHESIS
    // a compute word holds off the next word
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && (s_data.func == mdp_pkg::FUNC_COMPUTE) |=> !s_ready)
        else $error("input accepted right after a compute word");

    // no word accepted while products are in flight
    assert property (@(posedge aclk) disable iff (!aresetn)
        status.busy |-> !s_ready)
        else $error("input ready while pipeline busy");

    // result register never overwritten while still waiting
    assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load_out |-> (!m_valid || m_ready))
        else $error("pending result overwritten");

    // a loaded result is presented next cycle
    assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load_out |=> m_valid)
        else $error("loaded result not valid");
`endif

endmodule

`default_nettype wire

### sv/mdp_datapath.sv
// ----------------------------------------------------------------------------
// mdp_datapath
// Matrix storage, registered reads, multiplier, accumulator and result
// register.
// ----------------------------------------------------------------------------
`default_nettype none

module mdp_datapath (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire mdp_pkg::in_item_t in_item,
    input  wire mdp_pkg::cmd_t    cmd,
    output mdp_pkg::status_t      status,
    output mdp_pkg::out_item_t    out_item
);

    logic [mdp_pkg::DATA_W-1:0] mem_a [mdp_pkg::DEPTH];
    logic [mdp_pkg::DATA_W-1:0] mem_b [mdp_pkg::DEPTH];

    logic [mdp_pkg::ADDR_W-1:0]  wr_addr;
    logic [mdp_pkg::ADDR_W-1:0]  rd_addr_a;
    logic [mdp_pkg::ADDR_W-1:0]  rd_addr_b;
    logic [mdp_pkg::FIELD_W-1:0] row_reg;
    logic [mdp_pkg::FIELD_W-1:0] column_reg;
    logic [mdp_pkg::DATA_W-1:0]  a_rd_reg;
    logic [mdp_pkg::DATA_W-1:0]  b_rd_reg;
    logic [mdp_pkg::DATA_W-1:0]  mul_reg;
    logic [mdp_pkg::DATA_W-1:0]  mul_next;
    logic [mdp_pkg::DATA_W-1:0]  acc_reg;
    logic                        rd_v_reg;
    logic                        mul_v_reg;
    mdp_pkg::out_item_t          out_reg;

    assign wr_addr   = {mdp_pkg::IDX_W'(in_item.row), mdp_pkg::IDX_W'(in_item.column)};
    assign rd_addr_a = {mdp_pkg::IDX_W'(row_reg), cmd.rd_index};
    assign rd_addr_b = {cmd.rd_index, mdp_pkg::IDX_W'(column_reg)};
    assign mul_next  = a_rd_reg * b_rd_reg;

    always_ff @(posedge aclk) begin
        if (cmd.wr_a) begin
            mem_a[wr_addr] <= in_item.value;
        end
        if (cmd.wr_b) begin
            mem_b[wr_addr] <= in_item.value;
        end
        a_rd_reg <= mem_a[rd_addr_a];
        b_rd_reg <= mem_b[rd_addr_b];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rd_v_reg  <= 1'b0;
            mul_v_reg <= 1'b0;
        end else begin
            rd_v_reg  <= cmd.issue;
            mul_v_reg <= rd_v_reg;
        end
    end

    always_ff @(posedge aclk) begin
        mul_reg <= mul_next;
        if (cmd.start) begin
            row_reg    <= in_item.row;
            column_reg <= in_item.column;
            acc_reg    <= '0;
        end else if (mul_v_reg) begin
            acc_reg <= acc_reg + mul_reg;
        end
        if (cmd.load_out) begin
            out_reg.product    <= acc_reg;
            out_reg.out_row    <= row_reg;
            out_reg.out_column <= column_reg;
        end
    end

    assign status.busy = rd_v_reg | mul_v_reg;
    assign out_item    = out_reg;

endmodule

`default_nettype wire

### sv/mdp_controller.sv
// ----------------------------------------------------------------------------
// mdp_controller
// Sequencer for writes and dot product requests, dimension register and
// output word valid.
// ----------------------------------------------------------------------------
`default_nettype none

module mdp_controller (
    input  wire logic                      aclk,
    input  wire logic                      aresetn,
    input  wire logic                      cfg_wr_en,
    input  wire logic [mdp_pkg::DIM_W-1:0] cfg_wr_data,
    input  wire logic                      s_valid,
    output logic                           s_ready,
    input  wire mdp_pkg::in_item_t         in_item,
    output logic                           m_valid,
    input  wire logic                      m_ready,
    output mdp_pkg::cmd_t                  cmd,
    input  wire mdp_pkg::status_t          status
);

    mdp_pkg::state_t             state_reg;
    mdp_pkg::state_t             state_next;
    logic [mdp_pkg::LEN_W-1:0]   p_reg;
    logic [mdp_pkg::LEN_W-1:0]   p_next;
    logic [mdp_pkg::DIM_W-1:0]   dimension_reg;
    logic                        m_valid_reg;
    logic                        m_valid_next;
    logic [mdp_pkg::LEN_W-1:0]   len;
    logic                        in_range;

    always_comb begin
        if (int'(dimension_reg) > mdp_pkg::MAX_DIM) begin
            len = mdp_pkg::LEN_W'(mdp_pkg::MAX_DIM);
        end else begin
            len = mdp_pkg::LEN_W'(dimension_reg);
        end
    end

    assign in_range = (int'(in_item.row) < mdp_pkg::MAX_DIM) &&
                      (int'(in_item.column) < mdp_pkg::MAX_DIM);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= mdp_pkg::ST_IDLE;
            p_reg         <= '0;
            dimension_reg <= mdp_pkg::DIM_RESET;
            m_valid_reg   <= 1'b0;
        end else begin
            state_reg   <= state_next;
            p_reg       <= p_next;
            m_valid_reg <= m_valid_next;
            if (cfg_wr_en) begin
                dimension_reg <= cfg_wr_data;
            end
        end
    end

    always_comb begin
        state_next   = state_reg;
        p_next       = p_reg;
        s_ready      = 1'b0;
        cmd          = '0;
        cmd.rd_index = p_reg[mdp_pkg::IDX_W-1:0];
        case (state_reg)
            mdp_pkg::ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    case (in_item.func)
                        mdp_pkg::FUNC_WRITE_A: begin
                            cmd.wr_a = in_range;
                        end
                        mdp_pkg::FUNC_WRITE_B: begin
                            cmd.wr_b = in_range;
                        end
                        mdp_pkg::FUNC_COMPUTE: begin
                            cmd.start = 1'b1;
                            p_next    = '0;
                            if (in_range && (len != '0)) begin
                                state_next = mdp_pkg::ST_ISSUE;
                            end else begin
                                state_next = mdp_pkg::ST_DRAIN;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            mdp_pkg::ST_ISSUE: begin
                cmd.issue = 1'b1;
                if (p_reg == len - 1'b1) begin
                    state_next = mdp_pkg::ST_DRAIN;
                end else begin
                    p_next = p_reg + 1'b1;
                end
            end
            mdp_pkg::ST_DRAIN: begin
                if (!status.busy) begin
                    state_next = mdp_pkg::ST_FINISH;
                end
            end
            mdp_pkg::ST_FINISH: begin
                if (!m_valid_reg || m_ready) begin
                    cmd.load_out = 1'b1;
                    state_next   = mdp_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = mdp_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (cmd.load_out) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    assign m_valid = m_valid_reg;

endmodule

`default_nettype wire
